FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for triangle plane setup
// Stage counts of the pipeline and the sideband record that rides along.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int TARGET_BITS = 30;
  localparam int SQ_STEPS    = 32;   // one result bit of the square root per stage
  localparam int DIV_STEPS   = 15;   // one quotient bit per stage
  localparam int SQ0         = 8;    // first square root stage
  localparam int DV0         = SQ0 + SQ_STEPS;
  localparam int NST         = DV0 + DIV_STEPS + 5;

  localparam logic signed [25:0] DIST_MAX = 26'sd33554431;
  localparam logic signed [25:0] DIST_MIN = -26'sd33554431 - 26'sd1;

  typedef struct packed {
    logic [23:0] v0x;
    logic [23:0] v0y;
    logic [23:0] v0z;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
    logic [2:0]  neg;
    logic        degen;
  } side_t;

endpackage

FILE: src/triangle_plane_setup.sv
// ----------------------------------------------------------------------------
// triangle_plane_setup: unit normal and plane distance of one triangle
// Cross product, normalization, orientation against a reference normal,
// and the saturated plane distance, as one fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries three vertices in Q15.8 and a
//   reference normal in Q1.14. Result channel (out_valid / out_ready) carries
//   the unit normal, plane distance, swap flag and degenerate flag.
//   Throughput is one triangle per cycle while out_ready is not held low; the
//   32-stage square root and the 15-stage divider each retire one result bit
//   per stage, and set the depth.
//   Each stage holds its beat only while the stage ahead is full and held,
//   so bubbles close up and in_ready stays high while any stage is empty.
//   When the receiver stalls, the output register holds its beat and the
//   pipe keeps filling until every stage is full; then in_ready drops.
//   Reset clears every valid bit; the datapath registers need no reset.
// ----------------------------------------------------------------------------
module triangle_plane_setup (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_v0_x,
  input  logic signed [23:0] in_v0_y,
  input  logic signed [23:0] in_v0_z,
  input  logic signed [23:0] in_v1_x,
  input  logic signed [23:0] in_v1_y,
  input  logic signed [23:0] in_v1_z,
  input  logic signed [23:0] in_v2_x,
  input  logic signed [23:0] in_v2_y,
  input  logic signed [23:0] in_v2_z,
  input  logic signed [15:0] in_ref_nx,
  input  logic signed [15:0] in_ref_ny,
  input  logic signed [15:0] in_ref_nz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic signed [25:0] out_plane_dist,
  output logic               out_winding_swapped,
  output logic               out_degenerate
);

  import tps_pkg::*;

  function automatic logic [5:0] bit_len(logic [49:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  side_t          side_r [NST];
  side_t          side_in [NST];

  // stage k advances when empty or when the stage ahead advances
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_r & ~en) | ({vld_r[NST-2:0], in_valid} & en);
    end
  end

  // ---------------- stage 0: edges
  logic signed [24:0] e_r [6];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_r[0] <= 25'(in_v1_x) - 25'(in_v0_x);
      e_r[1] <= 25'(in_v1_y) - 25'(in_v0_y);
      e_r[2] <= 25'(in_v1_z) - 25'(in_v0_z);
      e_r[3] <= 25'(in_v2_x) - 25'(in_v0_x);
      e_r[4] <= 25'(in_v2_y) - 25'(in_v0_y);
      e_r[5] <= 25'(in_v2_z) - 25'(in_v0_z);
    end
  end

  // ---------------- stage 1: cross product terms
  logic signed [49:0] p_r [6];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];
    end
  end

  // ---------------- stage 2: cross product
  logic signed [50:0] c_nxt [3];
  logic signed [50:0] c_r [3];
  always_comb begin
    c_nxt[0] = 51'(p_r[0]) - 51'(p_r[1]);
    c_nxt[1] = 51'(p_r[2]) - 51'(p_r[3]);
    c_nxt[2] = 51'(p_r[4]) - 51'(p_r[5]);
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) c_r[i] <= c_nxt[i];
    end
  end

  // ---------------- stage 3: magnitudes and maximum
  logic [49:0] a_nxt [3];
  logic [49:0] a3_r [3];
  logic [49:0] m_nxt;
  logic [49:0] m_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nxt[i] = c_r[i][50] ? 50'(-c_r[i]) : 50'(c_r[i]);
    end
    m_nxt = a_nxt[0];
    if (a_nxt[1] > m_nxt) m_nxt = a_nxt[1];
    if (a_nxt[2] > m_nxt) m_nxt = a_nxt[2];
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) a3_r[i] <= a_nxt[i];
      m_r <= m_nxt;
    end
  end

  // ---------------- stage 4: bit length of the maximum
  logic [49:0] a4_r [3];
  logic [5:0]  bl_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) a4_r[i] <= a3_r[i];
      bl_r <= bit_len(m_r);
    end
  end

  // ---------------- stage 5: common scaling, maximum into [2^29, 2^30)
  logic [49:0]       sh_nxt [3];
  logic [2:0][29:0]  as_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl_r > 6'(TARGET_BITS)) sh_nxt[i] = a4_r[i] >> (bl_r - 6'(TARGET_BITS));
      else                        sh_nxt[i] = a4_r[i] << (6'(TARGET_BITS) - bl_r);
    end
  end
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) as_r[i] <= sh_nxt[i][29:0];
    end
  end

  // ---------------- stage 6: squares
  logic [59:0]      sq_r [3];
  logic [2:0][29:0] as6_r;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= 60'(as_r[i]) * 60'(as_r[i]);
      as6_r <= as_r;
    end
  end

  // ---------------- stage 7: sum of squares
  logic [61:0]      sum_r;
  logic [2:0][29:0] as7_r;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      sum_r <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
      as7_r <= as6_r;
    end
  end

  // ---------------- square root, one result bit per stage
  logic [62:0]      sx_r [SQ_STEPS];
  logic [62:0]      sr_r [SQ_STEPS];
  logic [2:0][29:0] sa_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    localparam int SH = 62 - 2 * j;
    logic [62:0]      x_in;
    logic [62:0]      r_in;
    logic [62:0]      bt;
    logic [62:0]      x_n;
    logic [62:0]      r_n;
    logic [2:0][29:0] a_in;
    if (j == 0) begin : g_first
      assign x_in = {1'b0, sum_r};
      assign r_in = '0;
      assign a_in = as7_r;
    end else begin : g_next
      assign x_in = sx_r[j-1];
      assign r_in = sr_r[j-1];
      assign a_in = sa_r[j-1];
    end
    always_comb begin
      bt = 63'(1) << SH;
      if (x_in >= r_in + bt) begin
        x_n = x_in - (r_in + bt);
        r_n = (r_in >> 1) + bt;
      end else begin
        x_n = x_in;
        r_n = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en[SQ0+j]) begin
        sx_r[j] <= x_n;
        sr_r[j] <= r_n;
        sa_r[j] <= a_in;
      end
    end
  end

  // ---------------- restoring divide, one quotient bit per stage
  logic [2:0][45:0] dr_r [DIV_STEPS];
  logic [2:0][14:0] dq_r [DIV_STEPS];
  logic [31:0]      dl_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
    localparam int SH = DIV_STEPS - 1 - k;
    logic [2:0][45:0] rem_in;
    logic [2:0][14:0] q_in;
    logic [31:0]      l_in;
    logic [45:0]      dsh;
    logic [2:0][45:0] rem_n;
    logic [2:0][14:0] q_n;
    if (k == 0) begin : g_first
      assign l_in = sr_r[SQ_STEPS-1][31:0];
      assign q_in = '0;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {2'b00, sa_r[SQ_STEPS-1][i], 14'b0} + 46'(l_in >> 1);
        end
      end
    end else begin : g_next
      assign l_in   = dl_r[k-1];
      assign q_in   = dq_r[k-1];
      assign rem_in = dr_r[k-1];
    end
    always_comb begin
      dsh = 46'(l_in) << SH;
      for (int i = 0; i < 3; i++) begin
        rem_n[i] = rem_in[i];
        q_n[i]   = q_in[i];
        if (rem_in[i] >= dsh) begin
          rem_n[i]    = rem_in[i] - dsh;
          q_n[i][SH]  = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[DV0+k]) begin
        dr_r[k] <= rem_n;
        dq_r[k] <= q_n;
        dl_r[k] <= l_in;
      end
    end
  end

  localparam int SN = DV0 + DIV_STEPS;

  // ---------------- signed normal
  logic signed [15:0] n_r [3];
  always_ff @(posedge clk) begin
    if (en[SN]) begin
      for (int i = 0; i < 3; i++) begin
        if (side_r[SN-1].degen)       n_r[i] <= '0;
        else if (side_r[SN-1].neg[i]) n_r[i] <= -$signed({1'b0, dq_r[DIV_STEPS-1][i]});
        else                          n_r[i] <= $signed({1'b0, dq_r[DIV_STEPS-1][i]});
      end
    end
  end

  // ---------------- products with the reference normal
  logic signed [31:0] rp_r [3];
  logic signed [15:0] n1_r [3];
  always_ff @(posedge clk) begin
    if (en[SN+1]) begin
      rp_r[0] <= n_r[0] * $signed(side_r[SN].rx);
      rp_r[1] <= n_r[1] * $signed(side_r[SN].ry);
      rp_r[2] <= n_r[2] * $signed(side_r[SN].rz);
      for (int i = 0; i < 3; i++) n1_r[i] <= n_r[i];
    end
  end

  // ---------------- orientation
  logic signed [33:0] dot;
  logic signed [15:0] n2_r [3];
  logic               swp2_r;
  assign dot = 34'(rp_r[0]) + 34'(rp_r[1]) + 34'(rp_r[2]);
  always_ff @(posedge clk) begin
    if (en[SN+2]) begin
      swp2_r <= dot[33];
      for (int i = 0; i < 3; i++) n2_r[i] <= dot[33] ? -n1_r[i] : n1_r[i];
    end
  end

  // ---------------- products with vertex 0
  logic signed [39:0] dp_r [3];
  logic signed [15:0] n3_r [3];
  logic               swp3_r;
  always_ff @(posedge clk) begin
    if (en[SN+3]) begin
      dp_r[0] <= n2_r[0] * $signed(side_r[SN+2].v0x);
      dp_r[1] <= n2_r[1] * $signed(side_r[SN+2].v0y);
      dp_r[2] <= n2_r[2] * $signed(side_r[SN+2].v0z);
      for (int i = 0; i < 3; i++) n3_r[i] <= n2_r[i];
      swp3_r <= swp2_r;
    end
  end

  // ---------------- distance: round half up, saturate, output register
  logic signed [41:0] ds;
  logic signed [41:0] dt;
  logic signed [27:0] dq;
  logic signed [25:0] dist_nxt;
  always_comb begin
    ds = 42'(dp_r[0]) + 42'(dp_r[1]) + 42'(dp_r[2]);
    dt = ds + 42'sd8192;
    dq = dt[41:14];
    if (dq > 28'(DIST_MAX))      dist_nxt = DIST_MAX;
    else if (dq < 28'(DIST_MIN)) dist_nxt = DIST_MIN;
    else                         dist_nxt = dq[25:0];
  end
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_norm_x          <= n3_r[0];
      out_norm_y          <= n3_r[1];
      out_norm_z          <= n3_r[2];
      out_plane_dist      <= dist_nxt;
      out_winding_swapped <= swp3_r;
      out_degenerate      <= side_r[NST-2].degen;
    end
  end

  // ---------------- sideband: fill sign and degenerate flags at the cross stage
  always_comb begin
    side_in[0] = '{v0x: in_v0_x, v0y: in_v0_y, v0z: in_v0_z,
                   rx: in_ref_nx, ry: in_ref_ny, rz: in_ref_nz,
                   neg: 3'b000, degen: 1'b0};
    for (int k = 1; k < NST; k++) begin
      side_in[k] = side_r[k-1];
    end
    side_in[3].neg   = {c_r[2][50], c_r[1][50], c_r[0][50]};
    side_in[3].degen = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) side_r[k] <= side_in[k];
    end
  end

  // ---------------- assertions
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0 &&
      out_plane_dist == '0 && !out_winding_swapped)
    else $error("degenerate beat carries nonzero result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held while output register empty");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_norm_x <= 16'sd16384 && out_norm_x >= -16'sd16384 &&
      out_norm_y <= 16'sd16384 && out_norm_y >= -16'sd16384 &&
      out_norm_z <= 16'sd16384 && out_norm_z >= -16'sd16384)
    else $error("normal component out of Q1.14 unit range");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-2] && !en[NST-1] |=> vld_r[NST-2])
    else $error("beat dropped while output stalled");

endmodule
